>>> rtl/csdc_pkg.sv
`timescale 1ns / 1ps
package csdc_pkg;

  localparam int BASE_W     = 10;
  localparam int PROD_W     = 2 * BASE_W;
  localparam int CUBE_W     = 3 * BASE_W;
  localparam int KEY_W      = 31;
  localparam int COUNT_W    = 2;
  localparam int TOTAL_W    = 13;
  localparam int SUM_W      = 44;
  localparam int SIZE_W     = 4;
  localparam int SLOT_W     = 1 + COUNT_W + KEY_W;

  localparam int DEFAULT_TABLE_BITS = 12;

  localparam logic [SIZE_W-1:0]  SIZE_RESET = 4'd12;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 2'd3;

  localparam int PROBE_STEP = 51679;
  localparam int MIX_SHIFT_A = 20;
  localparam int MIX_SHIFT_B = 12;
  localparam int MIX_SHIFT_C = 7;
  localparam int MIX_SHIFT_D = 4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQ_A,
    ST_CU_A,
    ST_SQ_B,
    ST_CU_B,
    ST_SUM,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                valid;
    logic [COUNT_W-1:0]  count;
    logic [KEY_W-1:0]    key;
  } slot_t;

endpackage

>>> rtl/cube_sum_duplicate_counter.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Beat payload
// in       in   in_valid_i/in_stall_o  first_base_i, second_base_i
// out      out  out_valid_o/out_stall_i cube_sum_o, became_duplicate_o,
//                                       duplicate_total_o, duplicate_checksum_o, table_full_o
// cfg      in   cfg_we_i               cfg_wdata_i (table_size_log2)
//
// Per beat, P = probes made (1 .. 2^size): one shared 20x10 multiplier forms the two cubes
// in four steps (SQ_A, CU_A, SQ_B, CU_B), a sum step (ST_SUM) adds them, and
// each probe is a read plus a compare on the single-port slot RAM.
// After reset a clearing pass writes all 2^TABLE_BITS slots before the first beat.
// A finished result waits in the output register; a new beat is taken meanwhile.
module cube_sum_duplicate_counter #(
  parameter int TABLE_BITS = csdc_pkg::DEFAULT_TABLE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [csdc_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [csdc_pkg::BASE_W-1:0] first_base_i,
  input  logic [csdc_pkg::BASE_W-1:0] second_base_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [csdc_pkg::KEY_W-1:0]  cube_sum_o,
  output logic                        became_duplicate_o,
  output logic [csdc_pkg::TOTAL_W-1:0] duplicate_total_o,
  output logic [csdc_pkg::SUM_W-1:0]  duplicate_checksum_o,
  output logic                        table_full_o
);
  import csdc_pkg::*;

  localparam int SLOTS  = 1 << TABLE_BITS;
  localparam int UB_W   = $clog2(TABLE_BITS + 1);
  localparam int STEP_W = TABLE_BITS + 16;
  localparam int HASH_W = ((STEP_W > KEY_W) ? STEP_W : KEY_W) + 1;

  state_e state_q, state_d;

  logic [SIZE_W-1:0]     cfg_q;
  logic [BASE_W-1:0]     a_q, b_q;
  logic [CUBE_W-1:0]     prod_q, acc_q;
  logic [KEY_W-1:0]      key_q;
  logic [HASH_W-1:0]     hash_q;
  logic [TABLE_BITS-1:0] idx_q, k_q, clr_q;
  logic                  became_q, full_q;
  logic [TOTAL_W-1:0]    total_q;
  logic [SUM_W-1:0]      sum_q;

  logic                  out_valid_q;
  logic [KEY_W-1:0]      out_key_q;
  logic                  out_became_q, out_full_q;
  logic [TOTAL_W-1:0]    out_total_q;
  logic [SUM_W-1:0]      out_sum_q;

  // sequencer controls
  logic                  mul_square, mul_use_b;
  logic                  ram_we;
  logic [TABLE_BITS-1:0] ram_addr;
  slot_t                 ram_wdata, ram_rdata;
  logic [SLOT_W-1:0]     ram_rbits;

  logic [UB_W-1:0]       used_bits;
  logic [TABLE_BITS-1:0] mask;
  logic [HASH_W-1:0]     mix1, mix2;
  logic [TABLE_BITS-1:0] idx;
  logic [PROD_W-1:0]     mul_a;
  logic [BASE_W-1:0]     mul_b;
  logic [CUBE_W-1:0]     mul_p;
  logic                  hit, empty, bump, dup_now, out_load;

  always_comb begin
    if (cfg_q == '0) begin
      used_bits = UB_W'(1);
    end else if (32'(cfg_q) > TABLE_BITS) begin
      used_bits = UB_W'(TABLE_BITS);
    end else begin
      used_bits = UB_W'(cfg_q);
    end
    mask = {TABLE_BITS{1'b1}} >> (UB_W'(TABLE_BITS) - used_bits);
  end

  always_comb begin
    mix1 = hash_q ^ (hash_q >> MIX_SHIFT_A) ^ (hash_q >> MIX_SHIFT_B);
    mix2 = mix1 ^ (mix1 >> MIX_SHIFT_C) ^ (mix1 >> MIX_SHIFT_D);
    idx  = mix2[TABLE_BITS-1:0] & mask;
  end

  assign mul_b = mul_use_b ? b_q : a_q;
  assign mul_a = mul_square ? PROD_W'(mul_b) : prod_q[PROD_W-1:0];
  assign mul_p = CUBE_W'(mul_a) * CUBE_W'(mul_b);

  assign ram_rdata = slot_t'(ram_rbits);
  assign empty     = !ram_rdata.valid;
  assign hit       = empty || (ram_rdata.key == key_q);
  assign bump      = !empty && (ram_rdata.count != COUNT_MAX);
  assign dup_now   = bump && (ram_rdata.count == COUNT_ONE);
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (&clr_q) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_SQ_A;
      ST_SQ_A:  state_d = ST_CU_A;
      ST_CU_A:  state_d = ST_SQ_B;
      ST_SQ_B:  state_d = ST_CU_B;
      ST_CU_B:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_READ;
      ST_READ:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (hit || k_q == mask) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    mul_square = 1'b0;
    mul_use_b  = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = idx_q;
    ram_wdata  = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
      end
      ST_IDLE:  in_stall_o = 1'b0;
      ST_SQ_A:  mul_square = 1'b1;
      ST_CU_A:  mul_square = 1'b0;
      ST_SQ_B: begin
        mul_square = 1'b1;
        mul_use_b  = 1'b1;
      end
      ST_CU_B:  mul_use_b = 1'b1;
      ST_READ:  ram_addr = idx;
      ST_CHECK: begin
        ram_we          = hit && (empty || bump);
        ram_wdata.valid = 1'b1;
        ram_wdata.key   = key_q;
        ram_wdata.count = empty ? COUNT_ONE : ram_rdata.count + COUNT_ONE;
      end
      default: ;
    endcase
  end

  csdc_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rbits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cfg_q       <= SIZE_RESET;
      clr_q       <= '0;
      total_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == ST_CHECK && hit && dup_now) begin
        total_q <= total_q + 1'b1;
        sum_q   <= sum_q + SUM_W'(key_q);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        a_q <= first_base_i;
        b_q <= second_base_i;
      end
      ST_SQ_A, ST_CU_A, ST_CU_B: prod_q <= mul_p;
      ST_SQ_B: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      ST_SUM: begin
        key_q    <= KEY_W'(acc_q) + KEY_W'(prod_q);
        hash_q   <= HASH_W'(KEY_W'(acc_q) + KEY_W'(prod_q));
        k_q      <= '0;
        became_q <= 1'b0;
        full_q   <= 1'b0;
      end
      ST_READ: idx_q <= idx;
      ST_CHECK: begin
        if (hit) begin
          became_q <= dup_now;
        end else if (k_q == mask) begin
          full_q <= 1'b1;
        end else begin
          k_q    <= k_q + 1'b1;
          hash_q <= hash_q + HASH_W'(PROBE_STEP);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_key_q    <= key_q;
      out_became_q <= became_q;
      out_full_q   <= full_q;
      out_total_q  <= total_q;
      out_sum_q    <= sum_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign cube_sum_o           = out_key_q;
  assign became_duplicate_o   = out_became_q;
  assign duplicate_total_o    = out_total_q;
  assign duplicate_checksum_o = out_sum_q;
  assign table_full_o         = out_full_q;

endmodule

>>> rtl/csdc_ram.sv
`timescale 1ns / 1ps
module csdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> verif/cube_sum_duplicate_counter_check.sv
`timescale 1ns / 1ps
module cube_sum_duplicate_counter_check #(
  parameter int TABLE_BITS = csdc_pkg::DEFAULT_TABLE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [csdc_pkg::SIZE_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [csdc_pkg::BASE_W-1:0]  first_base_i,
  input  logic [csdc_pkg::BASE_W-1:0]  second_base_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [csdc_pkg::KEY_W-1:0]   cube_sum_i,
  input  logic                         became_duplicate_i,
  input  logic [csdc_pkg::TOTAL_W-1:0] duplicate_total_i,
  input  logic [csdc_pkg::SUM_W-1:0]   duplicate_checksum_i,
  input  logic                         table_full_i,
  output int                           mismatch_count_o,
  output int                           outstanding_o
);

  localparam int SLOTS = 1 << TABLE_BITS;

  typedef struct packed {
    logic [csdc_pkg::KEY_W-1:0]   cube_sum;
    logic                         became;
    logic [csdc_pkg::TOTAL_W-1:0] total;
    logic [csdc_pkg::SUM_W-1:0]   checksum;
    logic                         full;
  } tally_t;

  logic                           slot_used [SLOTS];
  logic [csdc_pkg::KEY_W-1:0]     slot_cube [SLOTS];
  logic [csdc_pkg::COUNT_W-1:0]   slot_hits [SLOTS];
  logic [csdc_pkg::SIZE_W-1:0]    size_reg;
  logic [csdc_pkg::TOTAL_W-1:0]   dup_keys;
  logic [63:0]                    dup_key_sum;
  tally_t                         expected_tallies [$];
  tally_t                         want_tally;
  int                             mismatches;

  function automatic logic [TABLE_BITS-1:0] mix_slot(input logic [63:0] h,
                                                     input logic [TABLE_BITS-1:0] mask);
    logic [63:0] m;
    m = h ^ (h >> csdc_pkg::MIX_SHIFT_A) ^ (h >> csdc_pkg::MIX_SHIFT_B);
    m = m ^ (m >> csdc_pkg::MIX_SHIFT_C) ^ (m >> csdc_pkg::MIX_SHIFT_D);
    return m[TABLE_BITS-1:0] & mask;
  endfunction

  // Looks the key up, updates the table and the running totals.
  function automatic tally_t tally_pair(input logic [csdc_pkg::BASE_W-1:0] a,
                                        input logic [csdc_pkg::BASE_W-1:0] b);
    tally_t                t;
    logic [63:0]           cube_a;
    logic [63:0]           cube_b;
    logic [63:0]           cube_key;
    int                    bits;
    int                    span;
    int                    probe;
    logic [TABLE_BITS-1:0] mask;
    logic [TABLE_BITS-1:0] slot;
    bit                    settled;
    cube_a = 64'(a);
    cube_b = 64'(b);
    cube_a = cube_a * cube_a * cube_a;
    cube_b = cube_b * cube_b * cube_b;
    cube_key = (cube_a + cube_b) & 64'h7FFF_FFFF;
    bits = int'(size_reg);
    if (bits < 1) bits = 1;
    if (bits > TABLE_BITS) bits = TABLE_BITS;
    span = 1 << bits;
    mask = TABLE_BITS'(span - 1);
    probe = 0;
    settled = 1'b0;
    slot = '0;
    while (!settled && probe < span) begin
      slot = mix_slot(cube_key + 64'(probe) * 64'(csdc_pkg::PROBE_STEP), mask);
      if (!slot_used[slot] || slot_cube[slot] == cube_key[csdc_pkg::KEY_W-1:0]) settled = 1'b1;
      else probe++;
    end
    t.became = 1'b0;
    t.full = 1'b0;
    if (!settled) begin
      t.full = 1'b1;
    end else if (!slot_used[slot]) begin
      slot_used[slot] = 1'b1;
      slot_cube[slot] = cube_key[csdc_pkg::KEY_W-1:0];
      slot_hits[slot] = csdc_pkg::COUNT_ONE;
    end else if (slot_hits[slot] != csdc_pkg::COUNT_MAX) begin
      if (slot_hits[slot] == csdc_pkg::COUNT_ONE) begin
        t.became = 1'b1;
        dup_keys = dup_keys + 1'b1;
        dup_key_sum = dup_key_sum + cube_key;
      end
      slot_hits[slot] = slot_hits[slot] + 1'b1;
    end
    t.cube_sum = cube_key[csdc_pkg::KEY_W-1:0];
    t.total = dup_keys;
    t.checksum = dup_key_sum[csdc_pkg::SUM_W-1:0];
    return t;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 50) $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_cube[i] = '0;
        slot_hits[i] = '0;
      end
      size_reg = csdc_pkg::SIZE_RESET;
      dup_keys = '0;
      dup_key_sum = '0;
      expected_tallies.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) size_reg = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) expected_tallies.push_back(tally_pair(first_base_i,
                                                                           second_base_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_tallies.size() == 0) begin
          report_mismatch($sformatf("result beat cube_sum=%0d with nothing pending",
                                    cube_sum_i));
        end else begin
          want_tally = expected_tallies.pop_front();
          check_field("cube_sum", 64'(cube_sum_i), 64'(want_tally.cube_sum));
          check_field("became_duplicate", 64'(became_duplicate_i), 64'(want_tally.became));
          check_field("duplicate_total", 64'(duplicate_total_i), 64'(want_tally.total));
          check_field("duplicate_checksum", 64'(duplicate_checksum_i),
                      64'(want_tally.checksum));
          check_field("table_full", 64'(table_full_i), 64'(want_tally.full));
        end
      end
      mismatch_count_o <= mismatches;
      outstanding_o <= expected_tallies.size();
    end
  end

endmodule

>>> verif/cube_sum_duplicate_counter_tb.sv
`timescale 1ns / 1ps
module cube_sum_duplicate_counter_tb;

  localparam int TABLE_BITS = csdc_pkg::DEFAULT_TABLE_BITS;
  localparam int MAX_GAP = 20;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int DRAIN_CYCLES = 100;
  localparam int WATCHDOG_CYCLES = 8 * (3 * (1 << TABLE_BITS) + 64);
  // table sizes of the random phases, one nibble each
  localparam logic [63:0] PHASE_PLAN = {4'd13, 4'd8, 4'd10, 4'd0, 4'd6, 4'd15, 4'd4, 4'd11,
                                        4'd2, 4'd7, 4'd14, 4'd5, 4'd9, 4'd1, 4'd12, 4'd3};

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PULSE} stall_pattern_e;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [csdc_pkg::SIZE_W-1:0]  cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [csdc_pkg::BASE_W-1:0]  first_base_i;
  logic [csdc_pkg::BASE_W-1:0]  second_base_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [csdc_pkg::KEY_W-1:0]   cube_sum_o;
  logic                         became_duplicate_o;
  logic [csdc_pkg::TOTAL_W-1:0] duplicate_total_o;
  logic [csdc_pkg::SUM_W-1:0]   duplicate_checksum_o;
  logic                         table_full_o;

  int         mismatch_count;
  int         outstanding;
  int         burst_left = 0;
  int         quiet_cycles = 0;
  logic [19:0] recent_pairs [$];

  cube_sum_duplicate_counter #(
    .TABLE_BITS(TABLE_BITS)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .first_base_i        (first_base_i),
    .second_base_i       (second_base_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .cube_sum_o          (cube_sum_o),
    .became_duplicate_o  (became_duplicate_o),
    .duplicate_total_o   (duplicate_total_o),
    .duplicate_checksum_o(duplicate_checksum_o),
    .table_full_o        (table_full_o)
  );

  cube_sum_duplicate_counter_check #(
    .TABLE_BITS(TABLE_BITS)
  ) tally_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .first_base_i        (first_base_i),
    .second_base_i       (second_base_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .cube_sum_i          (cube_sum_o),
    .became_duplicate_i  (became_duplicate_o),
    .duplicate_total_i   (duplicate_total_o),
    .duplicate_checksum_i(duplicate_checksum_o),
    .table_full_i        (table_full_o),
    .mismatch_count_o    (mismatch_count),
    .outstanding_o       (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // {a1, b1, a2, b2}: two base pairs with equal cube sums
  function automatic logic [39:0] taxicab_ways(input int n);
    case (n)
      0: return {10'd1, 10'd12, 10'd9, 10'd10};
      1: return {10'd2, 10'd16, 10'd9, 10'd15};
      2: return {10'd2, 10'd24, 10'd18, 10'd20};
      3: return {10'd10, 10'd27, 10'd19, 10'd24};
      4: return {10'd4, 10'd32, 10'd18, 10'd30};
      5: return {10'd2, 10'd34, 10'd15, 10'd33};
      6: return {10'd9, 10'd34, 10'd16, 10'd33};
      7: return {10'd3, 10'd36, 10'd27, 10'd30};
      8: return {10'd17, 10'd39, 10'd26, 10'd36};
      default: return {10'd12, 10'd40, 10'd31, 10'd33};
    endcase
  endfunction

  task automatic send_pair(input logic [csdc_pkg::BASE_W-1:0] a,
                           input logic [csdc_pkg::BASE_W-1:0] b);
    int gap;
    first_base_i <= a;
    second_base_i <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic set_table_bits(input logic [csdc_pkg::SIZE_W-1:0] bits);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= bits;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    stall_pattern_e stall_mode;
    int             stretch;
    out_stall_i <= 1'b0;
    forever begin
      stall_mode = stall_pattern_e'($urandom_range(0, 3));
      stretch = $urandom_range(16, 160);
      for (int tick = 0; tick < stretch; tick++) begin
        @(posedge clk_i);
        case (stall_mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= (tick % 12) < 5;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("[cube_sum_duplicate_counter] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [39:0] ways;
    logic [19:0] pair;
    int          pick;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    first_base_i <= '0;
    second_base_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // key zero up to saturation, extreme bases, equal sums in both orders
    repeat (4) send_pair(10'd0, 10'd0);
    send_pair(10'd1023, 10'd1023);
    send_pair(10'd1023, 10'd0);
    send_pair(10'd0, 10'd1023);
    ways = taxicab_ways(0);
    send_pair(ways[39:30], ways[29:20]);
    send_pair(ways[19:10], ways[9:0]);
    send_pair(ways[29:20], ways[39:30]);
    send_pair(10'd167, 10'd436);
    send_pair(10'd228, 10'd423);
    send_pair(10'd255, 10'd414);
    send_pair(10'd414, 10'd255);
    send_pair(10'd341, 10'd682);
    send_pair(10'd682, 10'd341);
    send_pair(10'd512, 10'd511);

    // size 0 clamps to one bit: two slots fill and the table runs full
    set_table_bits(4'd0);
    ways = taxicab_ways(1);
    send_pair(ways[39:30], ways[29:20]);
    send_pair(ways[19:10], ways[9:0]);
    send_pair(10'd3, 10'd3);
    send_pair(10'd4, 10'd4);
    send_pair(ways[29:20], ways[39:30]);
    send_pair(10'd3, 10'd3);

    // above the table width clamps to the full table
    set_table_bits(4'd15);
    send_pair(ways[19:10], ways[9:0]);
    send_pair(10'd1023, 10'd1023);

    for (int phase = 0; phase < 16; phase++) begin
      set_table_bits(PHASE_PLAN[4*phase +: 4]);
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 35 && recent_pairs.size() > 0) begin
          pair = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
          if ($urandom_range(0, 1)) pair = {pair[9:0], pair[19:10]};
        end else if (pick < 50) begin
          ways = taxicab_ways($urandom_range(0, 9));
          pair = $urandom_range(0, 1) ? ways[39:20] : ways[19:0];
          if ($urandom_range(0, 1)) pair = {pair[9:0], pair[19:10]};
        end else if (pick < 60) begin
          pair[19:10] = $urandom_range(0, 15);
          pair[9:0] = $urandom_range(0, 15);
        end else begin
          pair[19:10] = $urandom_range(0, 1023);
          pair[9:0] = $urandom_range(0, 1023);
        end
        recent_pairs.push_back(pair);
        if (recent_pairs.size() > 32) void'(recent_pairs.pop_front());
        send_pair(pair[19:10], pair[9:0]);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[cube_sum_duplicate_counter] OK");
    end else begin
      $display("[cube_sum_duplicate_counter] ERROR");
    end
    $finish;
  end

endmodule
